// ----- src/sdtq_pkg.sv -----
// shared types and codes for the sorted deadline timer queue
`default_nettype none
package sdtq_pkg;
    localparam int TIME_W = 48;
    localparam int ID_W   = 32;
    localparam int HDL_W  = 5;

    typedef enum logic [1:0] {
        K_REGISTER = 2'd0,
        K_CANCEL   = 2'd1,
        K_TICK     = 2'd2,
        K_NONE     = 2'd3
    } t_kind;

    localparam logic [1:0] RK_REGISTER = 2'd0;
    localparam logic [1:0] RK_CANCEL   = 2'd1;
    localparam logic [1:0] RK_EXPIRY   = 2'd2;

    localparam logic ST_DONE = 1'b0;
    localparam logic ST_FULL = 1'b1;

    localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
endpackage
`default_nettype wire

// ----- src/sorted_deadline_timer_queue.sv -----
// top level of the sorted deadline timer queue: linked list kept in one memory
//
// channel   direction  signals
// command   in         i_start, o_busy, i_kind, i_time_value, i_relative,
//                      i_receiver, i_payload, i_handle
// result    out        o_valid, o_result_kind, o_status, o_slot,
//                      o_notify_target, o_token, o_last
//
// a beat is taken when i_start is high and o_busy low; one item at a time.
// register: lowest free slot found with a priority encoder, then the list is
// walked one entry at a time (memory read then compare), o_busy high
// throughout. cancel walks the same way. tick pops one due head at a time,
// at most 32 per tick. each result is shown for one cycle with o_valid; the
// result side cannot stall.
// reset (synchronous, active low) empties the list; memory needs no clearing.
`default_nettype none
module sorted_deadline_timer_queue #(
    parameter int CAPACITY = 32
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    output logic                            o_busy,
    input  wire logic [1:0]                 i_kind,
    input  wire logic [sdtq_pkg::TIME_W-1:0] i_time_value,
    input  wire logic                       i_relative,
    input  wire logic [sdtq_pkg::ID_W-1:0]  i_receiver,
    input  wire logic [sdtq_pkg::ID_W-1:0]  i_payload,
    input  wire logic [sdtq_pkg::HDL_W-1:0] i_handle,
    output logic                            o_valid,
    output logic [1:0]                      o_result_kind,
    output logic                            o_status,
    output logic [sdtq_pkg::HDL_W-1:0]      o_slot,
    output logic [sdtq_pkg::ID_W-1:0]       o_notify_target,
    output logic [sdtq_pkg::ID_W-1:0]       o_token,
    output logic                            o_last
);
    import sdtq_pkg::*;

    localparam int SW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = TIME_W + 2 * ID_W + SW;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RREQ  = 7'b0000010,
        S_RCMP  = 7'b0000100,
        S_CREQ  = 7'b0001000,
        S_CCMP  = 7'b0010000,
        S_TREQ  = 7'b0100000,
        S_TCMP  = 7'b1000000
    } t_state;

    // entry memory: {deadline, target, token, next}
    logic [EW-1:0] r_mem [CAPACITY];
    logic [EW-1:0] r_rdata;
    logic          mem_we;
    logic [SW-1:0] mem_waddr, mem_raddr;
    logic [EW-1:0] mem_wdata;
    // one write port and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) r_mem[mem_waddr] <= mem_wdata;
        r_rdata <= r_mem[mem_raddr];
    end

    wire logic [TIME_W-1:0] rd_dl   = r_rdata[EW-1 -: TIME_W];
    wire logic [ID_W-1:0]   rd_tg   = r_rdata[2*ID_W+SW-1 -: ID_W];
    wire logic [ID_W-1:0]   rd_tk   = r_rdata[ID_W+SW-1 -: ID_W];
    wire logic [SW-1:0]     rd_nx   = r_rdata[SW-1:0];

    t_state              r_state, n_state;
    logic [CAPACITY-1:0] r_used, n_used;
    logic [SW-1:0]       r_head, n_head;
    logic                r_empty, n_empty;
    logic [TIME_W-1:0]   r_tick, n_tick;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [TIME_W-1:0]   r_dl, n_dl;
    logic [ID_W-1:0]     r_tg, n_tg, r_tk, n_tk;
    logic [SW-1:0]       r_new, n_new, r_cur, n_cur, r_prev, n_prev;
    logic                r_hprev, n_hprev;
    logic [CW-1:0]       r_walk, n_walk;
    logic [HDL_W-1:0]    r_hdl, n_hdl;
    logic [5:0]          r_k, n_k;
    logic                r_ov, n_ov;
    logic [1:0]          r_ork, n_ork;
    logic                r_ost, n_ost, r_olast, n_olast;
    logic [HDL_W-1:0]    r_oslot, n_oslot;
    logic [ID_W-1:0]     r_otg, n_otg, r_otk, n_otk;

    // lowest free slot
    logic [SW-1:0] free_slot;
    logic          free_found;
    always_comb begin
        free_slot  = '0;
        free_found = 1'b0;
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_slot  = SW'(i);
                free_found = 1'b1;
            end
        end
    end

    logic [TIME_W:0] rel_sum;
    assign rel_sum = {1'b0, r_tick} + {1'b0, i_time_value};

    logic h_in_range;
    assign h_in_range = ({27'd0, i_handle} < 32'(CAPACITY));

    always_comb begin
        n_state = r_state;  n_used = r_used;  n_head = r_head;
        n_empty = r_empty;  n_tick = r_tick;  n_cnt = r_cnt;
        n_dl = r_dl; n_tg = r_tg; n_tk = r_tk; n_new = r_new;
        n_cur = r_cur; n_prev = r_prev; n_hprev = r_hprev; n_walk = r_walk;
        n_hdl = r_hdl; n_k = r_k;
        n_ov = 1'b0; n_ork = r_ork; n_ost = ST_DONE; n_olast = 1'b0;
        n_oslot = r_oslot; n_otg = '0; n_otk = '0;
        mem_we = 1'b0; mem_waddr = r_cur; mem_wdata = '0;
        mem_raddr = r_cur;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    case (i_kind)
                        K_REGISTER: begin
                            if (!free_found) begin
                                n_ov = 1'b1; n_ork = RK_REGISTER; n_ost = ST_FULL;
                                n_oslot = '0; n_olast = 1'b1;
                            end else begin
                                n_dl = i_relative ? (rel_sum[TIME_W] ? TIME_MAX
                                       : rel_sum[TIME_W-1:0]) : i_time_value;
                                n_tg = i_receiver; n_tk = i_payload;
                                n_new = free_slot; n_used[free_slot] = 1'b1;
                                n_cur = r_head; n_hprev = 1'b0; n_walk = '0;
                                n_state = S_RREQ;
                            end
                        end
                        K_CANCEL: begin
                            n_hdl = i_handle; n_cur = r_head; n_walk = '0;
                            if (h_in_range && r_used[SW'(i_handle)] && !r_empty) begin
                                n_used[SW'(i_handle)] = 1'b0;
                                if (r_head == SW'(i_handle)) begin
                                    if (r_cnt > CW'(1)) begin
                                        mem_raddr = r_head;
                                        n_state = S_CCMP; n_walk = CW'(CAPACITY);
                                    end else begin
                                        n_empty = 1'b1;
                                        n_ov = 1'b1; n_ork = RK_CANCEL;
                                        n_oslot = i_handle; n_olast = 1'b1;
                                    end
                                    n_cnt = r_cnt - CW'(1);
                                end else begin
                                    n_cnt = r_cnt - CW'(1);
                                    n_state = S_CREQ;
                                end
                            end else begin
                                n_ov = 1'b1; n_ork = RK_CANCEL;
                                n_oslot = i_handle; n_olast = 1'b1;
                            end
                        end
                        K_TICK: begin
                            n_tick = i_time_value; n_dl = i_time_value;
                            n_k = '0; n_cur = r_head; n_state = S_TREQ;
                        end
                        default: ;
                    endcase
                end
            end
            // insert walk: read entry at r_cur
            S_RREQ: begin
                if (r_empty || r_walk == r_cnt) begin
                    // write new entry; link after prev
                    mem_we = 1'b1; mem_waddr = r_new;
                    mem_wdata = {r_dl, r_tg, r_tk, r_cur};
                    if (r_empty) n_head = r_new;
                    else if (!r_hprev) n_head = r_new;
                    n_empty = 1'b0;
                    n_cnt = r_cnt + CW'(1);
                    if (r_hprev) begin
                        n_cur = r_prev;   // patch prev next in a later pass
                        mem_raddr = r_prev;
                        n_state = S_RCMP; n_walk = CW'(CAPACITY);
                    end else begin
                        n_ov = 1'b1; n_ork = RK_REGISTER;
                        n_oslot = HDL_W'(r_new); n_olast = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    mem_raddr = r_cur; n_state = S_RCMP;
                end
            end
            S_RCMP: begin
                if (r_walk == CW'(CAPACITY)) begin
                    // rewrite prev with next pointing at new
                    mem_we = 1'b1; mem_waddr = r_prev;
                    mem_wdata = {r_rdata[EW-1:SW], r_new};
                    n_ov = 1'b1; n_ork = RK_REGISTER;
                    n_oslot = HDL_W'(r_new); n_olast = 1'b1;
                    n_state = S_IDLE;
                end else if (rd_dl <= r_dl) begin
                    n_prev = r_cur; n_hprev = 1'b1; n_cur = rd_nx;
                    n_walk = r_walk + CW'(1); n_state = S_RREQ;
                end else begin
                    n_walk = r_cnt; n_state = S_RREQ;
                end
            end
            // cancel walk: find predecessor of handle
            S_CREQ: begin
                mem_raddr = r_cur; n_state = S_CCMP;
            end
            S_CCMP: begin
                if (r_walk == CW'(CAPACITY)) begin
                    n_head = rd_nx;
                    n_ov = 1'b1; n_ork = RK_CANCEL; n_oslot = r_hdl; n_olast = 1'b1;
                    n_state = S_IDLE;
                end else if (r_walk == CW'(CAPACITY) - CW'(1)) begin
                    // r_rdata holds handle entry; patch predecessor r_prev
                    mem_we = 1'b1; mem_waddr = r_prev;
                    mem_wdata = {r_dl, r_tg, r_tk, rd_nx};
                    n_ov = 1'b1; n_ork = RK_CANCEL; n_oslot = r_hdl; n_olast = 1'b1;
                    n_state = S_IDLE;
                end else if (r_walk >= r_cnt) begin
                    n_ov = 1'b1; n_ork = RK_CANCEL; n_oslot = r_hdl; n_olast = 1'b1;
                    n_state = S_IDLE;
                end else if (rd_nx == SW'(r_hdl)) begin
                    n_prev = r_cur; n_dl = rd_dl; n_tg = rd_tg; n_tk = rd_tk;
                    mem_raddr = SW'(r_hdl);
                    n_walk = CW'(CAPACITY) - CW'(1);
                end else begin
                    n_cur = rd_nx; n_walk = r_walk + CW'(1); n_state = S_CREQ;
                end
            end
            // tick: pop due heads
            S_TREQ: begin
                if (r_empty || r_cnt == '0 || r_k == 6'd32) begin
                    n_state = S_IDLE;
                end else begin
                    mem_raddr = r_head; n_state = S_TCMP;
                end
            end
            S_TCMP: begin
                if (rd_dl > r_dl) begin
                    n_state = S_IDLE;
                end else begin
                    n_ov = 1'b1; n_ork = RK_EXPIRY; n_oslot = HDL_W'(r_head);
                    n_otg = rd_tg; n_otk = rd_tk;
                    n_used[r_head] = 1'b0; n_cnt = r_cnt - CW'(1);
                    n_k = r_k + 6'd1;
                    if (r_cnt == CW'(1)) n_empty = 1'b1;
                    else n_head = rd_nx;
                    n_state = S_TREQ;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // a due head is last only when the following one cannot pop; hold one beat
    logic          r_pend;
    logic [1:0]    r_prk;
    logic [HDL_W-1:0] r_pslot;
    logic [ID_W-1:0]  r_ptg, r_ptk;
    logic tick_ends;
    assign tick_ends = (r_state == S_TREQ && (r_empty || r_cnt == '0 || r_k == 6'd32))
                    || (r_state == S_TCMP && rd_dl > r_dl);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE; r_used <= '0; r_head <= '0; r_empty <= 1'b1;
            r_tick <= '0; r_cnt <= '0; r_ov <= 1'b0; r_pend <= 1'b0;
            r_walk <= '0; r_k <= '0;
        end else begin
            r_state <= n_state; r_used <= n_used; r_head <= n_head;
            r_empty <= n_empty; r_tick <= n_tick; r_cnt <= n_cnt;
            r_walk <= n_walk; r_k <= n_k;
            if (n_ork == RK_EXPIRY && n_ov) begin
                // flush the held expiry as not last, hold the new one
                r_ov <= r_pend; r_pend <= 1'b1;
            end else if (tick_ends) begin
                r_ov <= r_pend; r_pend <= 1'b0;
            end else begin
                r_ov <= n_ov;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dl <= n_dl; r_tg <= n_tg; r_tk <= n_tk; r_new <= n_new;
        r_cur <= n_cur; r_prev <= n_prev; r_hprev <= n_hprev; r_hdl <= n_hdl;
        if (n_ork == RK_EXPIRY && n_ov) begin
            r_ork <= r_prk; r_oslot <= r_pslot; r_otg <= r_ptg; r_otk <= r_ptk;
            r_olast <= 1'b0; r_ost <= ST_DONE;
            r_prk <= n_ork; r_pslot <= n_oslot; r_ptg <= n_otg; r_ptk <= n_otk;
        end else if (tick_ends) begin
            r_ork <= r_prk; r_oslot <= r_pslot; r_otg <= r_ptg; r_otk <= r_ptk;
            r_olast <= 1'b1; r_ost <= ST_DONE;
        end else begin
            r_ork <= n_ork; r_oslot <= n_oslot; r_otg <= n_otg; r_otk <= n_otk;
            r_olast <= n_olast; r_ost <= n_ost;
        end
    end

    assign o_busy          = (r_state != S_IDLE);
    assign o_valid         = r_ov;
    assign o_result_kind   = r_ork;
    assign o_status        = r_ost;
    assign o_slot          = r_oslot;
    assign o_notify_target = r_otg;
    assign o_token         = r_otk;
    assign o_last          = r_olast;
endmodule
`default_nettype wire

// ----- src/sdtq_checker.sv -----
// port checker for the sorted deadline timer queue, bound to the top level
`default_nettype none
module sdtq_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_start,
    input wire logic       o_busy,
    input wire logic [1:0] i_kind,
    input wire logic       o_valid,
    input wire logic [1:0] o_result_kind,
    input wire logic       o_status,
    input wire logic       o_last
);
    import sdtq_pkg::*;

    // full status only on a register confirm
    a_full_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == ST_FULL) |-> (o_result_kind == RK_REGISTER && o_last))
        else $error("full status on non-register result");
    // confirms are always last
    a_conf_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind != RK_EXPIRY) |-> o_last)
        else $error("confirm without last");
    // an expiry beat is followed by more expiries or ends with last
    a_exp_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_result_kind == RK_EXPIRY && !o_last) |=>
        (!o_valid || o_result_kind == RK_EXPIRY))
        else $error("expiry run broken");
    // an accepted command either starts work or answers at once
    a_cmd_taken: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy && i_kind != K_NONE) |=> (o_busy || o_valid))
        else $error("accepted command left no trace");
    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_busy)
        else $error("activity after reset");
endmodule

bind sorted_deadline_timer_queue sdtq_checker u_sdtq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .i_kind(i_kind), .o_valid(o_valid), .o_result_kind(o_result_kind),
    .o_status(o_status), .o_last(o_last)
);
`default_nettype wire

// ----- sim/sorted_deadline_timer_queue_tb.sv -----
// testbench for the sorted deadline timer queue against a built-in list model
`default_nettype none
module sorted_deadline_timer_queue_tb;
    import sdtq_pkg::*;

    localparam int CAP       = 32;
    localparam int MAX_POP   = 32;
    localparam int CYC_LIMIT = 400000;
    localparam int N_RANDOM  = 200;
    localparam int DRAIN_CYC = 200;
    localparam logic [47:0] T_ALL = 48'hFFFF_FFFF_FFFF;

    typedef struct {
        logic [1:0]  kind;
        logic [47:0] tval;
        logic        rel;
        logic [31:0] rcv;
        logic [31:0] pay;
        logic [4:0]  hdl;
        bit          hold;
    } t_cmd;

    typedef struct {
        logic [1:0]  rk;
        logic        st;
        logic [4:0]  sl;
        logic [31:0] tg;
        logic [31:0] tk;
        logic        lst;
    } t_res;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic [1:0]  kind = '0;
    logic [47:0] tval = '0;
    logic        rel = 1'b0;
    logic [31:0] rcv = '0;
    logic [31:0] pay = '0;
    logic [4:0]  hdl = '0;
    logic        busy, valid, st, lst;
    logic [1:0]  rk;
    logic [4:0]  sl;
    logic [31:0] tg, tk;

    // timer list model
    logic [47:0] m_deadline [CAP];
    logic [31:0] m_target [CAP];
    logic [31:0] m_token [CAP];
    logic [4:0]  m_next [CAP];
    bit          m_used [CAP];
    logic [4:0]  m_head = '0;
    bit          m_empty = 1'b1;
    logic [47:0] m_now = '0;

    t_cmd pending_cmds[$];
    t_res expected_results[$];
    int   errors = 0;
    int   cycles = 0;
    bit   stim_done = 1'b0;

    sorted_deadline_timer_queue #(.CAPACITY(CAP)) uut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_kind(kind), .i_time_value(tval), .i_relative(rel),
        .i_receiver(rcv), .i_payload(pay), .i_handle(hdl),
        .o_valid(valid), .o_result_kind(rk), .o_status(st), .o_slot(sl),
        .o_notify_target(tg), .o_token(tk), .o_last(lst)
    );

    // clock
    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic int live_entries();
        int n;
        n = 0;
        for (int i = 0; i < CAP; i++) if (m_used[i]) n++;
        return n;
    endfunction

    function automatic void push_res(logic [1:0] r, logic s, logic [4:0] l,
                                     logic [31:0] g, logic [31:0] k, logic e);
        t_res x;
        x.rk = r; x.st = s; x.sl = l; x.tg = g; x.tk = k; x.lst = e;
        expected_results.push_back(x);
    endfunction

    // predict the results of one accepted command
    function automatic void predict_timer(t_cmd c);
        int n, s, walked, cnt;
        logic [47:0] d;
        logic [48:0] sum;
        logic [4:0] cur, prv;
        bit have_prev;
        n = live_entries();
        case (c.kind)
            K_REGISTER: begin
                s = -1;
                for (int i = CAP - 1; i >= 0; i--) if (!m_used[i]) s = i;
                if (s < 0) begin
                    push_res(RK_REGISTER, ST_FULL, '0, '0, '0, 1'b1);
                end else begin
                    d = c.tval;
                    if (c.rel) begin
                        sum = {1'b0, m_now} + {1'b0, c.tval};
                        d = sum[48] ? TIME_MAX : sum[47:0];
                    end
                    m_deadline[s] = d; m_target[s] = c.rcv; m_token[s] = c.pay;
                    m_next[s] = '0; m_used[s] = 1'b1;
                    if (m_empty || n == 0) begin
                        m_head = s[4:0]; m_empty = 1'b0;
                    end else begin
                        cur = m_head; prv = '0; have_prev = 1'b0; walked = 0;
                        while (walked < n && m_deadline[cur] <= d) begin
                            prv = cur; have_prev = 1'b1; cur = m_next[cur]; walked++;
                        end
                        if (walked < n) m_next[s] = cur;
                        if (have_prev) m_next[prv] = s[4:0];
                        else m_head = s[4:0];
                    end
                    push_res(RK_REGISTER, ST_DONE, s[4:0], '0, '0, 1'b1);
                end
            end
            K_CANCEL: begin
                if (m_used[c.hdl] && !m_empty) begin
                    if (m_head == c.hdl) begin
                        if (n > 1) m_head = m_next[c.hdl];
                        else m_empty = 1'b1;
                    end else begin
                        cur = m_head;
                        for (int i = 0; i + 1 < n; i++) begin
                            if (m_next[cur] == c.hdl) begin
                                m_next[cur] = m_next[c.hdl];
                                break;
                            end
                            cur = m_next[cur];
                        end
                    end
                    m_used[c.hdl] = 1'b0;
                end
                push_res(RK_CANCEL, ST_DONE, c.hdl, '0, '0, 1'b1);
            end
            K_TICK: begin
                m_now = c.tval;
                cnt = 0;
                while (!m_empty && n > 0 && cnt < MAX_POP) begin
                    cur = m_head;
                    if (m_deadline[cur] > c.tval) break;
                    push_res(RK_EXPIRY, ST_DONE, cur, m_target[cur], m_token[cur], 1'b0);
                    cnt++;
                    m_used[cur] = 1'b0;
                    n--;
                    if (n == 0) m_empty = 1'b1;
                    else m_head = m_next[cur];
                end
                if (cnt > 0) expected_results[$].lst = 1'b1;
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string what);
        errors++;
        $display("mismatch at cycle %0d: %s", cycles, what);
    endtask

    function automatic t_cmd mk(logic [1:0] k, logic [47:0] t, logic r,
                                logic [4:0] h);
        t_cmd c;
        c.kind = k; c.tval = t; c.rel = r; c.hdl = h;
        c.rcv = $urandom; c.pay = $urandom; c.hold = 1'b0;
        return c;
    endfunction

    // busy as seen at the last rising edge
    logic busy_at_edge = 1'b0;

    // driver: bursts with random gaps, optional hold until drained
    int  gap = 0;
    int  burst = 0;
    bit  sent_ok;
    t_cmd cur_cmd;
    always @(negedge clk) begin
        if (rst_n) begin
            sent_ok = start && !busy_at_edge;
            if (sent_ok) void'(pending_cmds.pop_front());
            if (pending_cmds.size() == 0) begin
                start <= 1'b0;
            end else if (start && !sent_ok) begin
                // keep holding the current beat
            end else if (pending_cmds[0].hold && expected_results.size() != 0) begin
                start <= 1'b0;
            end else if (gap > 0) begin
                gap--;
                start <= 1'b0;
            end else begin
                cur_cmd = pending_cmds[0];
                pending_cmds[0].hold = 1'b0;
                start <= 1'b1;
                kind <= cur_cmd.kind; tval <= cur_cmd.tval; rel <= cur_cmd.rel;
                rcv <= cur_cmd.rcv; pay <= cur_cmd.pay; hdl <= cur_cmd.hdl;
                if (burst > 0) burst--;
                else begin
                    burst = $urandom_range(0, 12);
                    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
            end
        end
    end

    // monitor: accept command beats and result beats at the rising edge
    always @(posedge clk) begin
        cycles <= cycles + 1;
        busy_at_edge <= busy;
        if (rst_n) begin
            if (start && !busy) predict_timer(pending_cmds[0]);
            if (valid) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("result beat with nothing expected");
                end else begin
                    t_res e;
                    e = expected_results.pop_front();
                    if (rk !== e.rk) report_mismatch($sformatf("kind %0d exp %0d", rk, e.rk));
                    if (st !== e.st) report_mismatch($sformatf("status %0d exp %0d", st, e.st));
                    if (sl !== e.sl) report_mismatch($sformatf("slot %0d exp %0d", sl, e.sl));
                    if (tg !== e.tg) report_mismatch($sformatf("target %h exp %h", tg, e.tg));
                    if (tk !== e.tk) report_mismatch($sformatf("token %h exp %h", tk, e.tk));
                    if (lst !== e.lst) report_mismatch($sformatf("last %0d exp %0d", lst, e.lst));
                end
            end
        end
        if (cycles >= CYC_LIMIT) begin
            $display("timeout");
            $display("== FAIL ==");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_cmd c;
        int r;
        logic [47:0] base;
        for (int i = 0; i < CAP; i++) begin
            m_used[i] = 1'b0; m_deadline[i] = '0; m_target[i] = '0;
            m_token[i] = '0; m_next[i] = '0;
        end
        // directed: extremes, equal deadlines, saturation, bad cancel, backwards tick
        pending_cmds.push_back(mk(K_TICK, 48'd100, 1'b0, '0));
        pending_cmds.push_back(mk(K_REGISTER, 48'd500, 1'b0, '0));
        pending_cmds.push_back(mk(K_REGISTER, 48'd500, 1'b0, '0));
        pending_cmds.push_back(mk(K_REGISTER, 48'd50, 1'b1, '0));
        pending_cmds.push_back(mk(K_REGISTER, T_ALL, 1'b1, '0));
        pending_cmds.push_back(mk(K_REGISTER, '0, 1'b0, '0));
        c = mk(K_REGISTER, T_ALL, 1'b0, '0);
        c.rcv = '1; c.pay = '1;
        pending_cmds.push_back(c);
        pending_cmds.push_back(mk(K_CANCEL, '0, 1'b0, 5'd31));
        pending_cmds.push_back(mk(K_CANCEL, '0, 1'b0, 5'd1));
        pending_cmds.push_back(mk(K_NONE, T_ALL, 1'b1, 5'd31));
        pending_cmds.push_back(mk(K_TICK, 48'd10, 1'b0, '0));
        pending_cmds.push_back(mk(K_TICK, 48'd600, 1'b0, '0));
        pending_cmds.push_back(mk(K_TICK, 48'd20, 1'b0, '0));
        // fill the table, overflow it, then flush everything at once
        for (int i = 0; i < CAP + 2; i++)
            pending_cmds.push_back(mk(K_REGISTER, 48'($urandom_range(0, 40)), 1'b1, '0));
        pending_cmds.push_back(mk(K_TICK, T_ALL, 1'b0, '0));
        pending_cmds.push_back(mk(K_TICK, T_ALL, 1'b0, '0));
        c = mk(K_TICK, '0, 1'b0, '0);
        c.hold = 1'b1;
        pending_cmds.push_back(c);
        // random mix: mostly registers and cancels near the current time
        base = '0;
        for (int i = 0; i < N_RANDOM; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) begin
                c = mk(K_REGISTER, 48'($urandom_range(0, 200)),
                       1'($urandom_range(0, 1)), '0);
                if (!c.rel) c.tval = base + c.tval;
                if ($urandom_range(0, 19) == 0) c.tval = 48'({$urandom, $urandom});
            end else if (r < 70) begin
                c = mk(K_CANCEL, 48'({$urandom, $urandom}), 1'b1,
                       5'($urandom_range(0, 31)));
            end else if (r < 97) begin
                base = base + 48'($urandom_range(0, 80));
                c = mk(K_TICK, base, 1'b0, '0);
                if ($urandom_range(0, 15) == 0) c.tval = 48'({$urandom, $urandom});
            end else begin
                c = mk(K_NONE, 48'({$urandom, $urandom}), 1'b1,
                       5'($urandom_range(0, 31)));
            end
            if (i == N_RANDOM / 2) c.hold = 1'b1;
            pending_cmds.push_back(c);
        end
        pending_cmds.push_back(mk(K_TICK, T_ALL, 1'b0, '0));
        pending_cmds.push_back(mk(K_TICK, T_ALL, 1'b0, '0));
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        wait (pending_cmds.size() == 0);
        wait (expected_results.size() == 0);
        repeat (DRAIN_CYC) @(posedge clk);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end
endmodule
`default_nettype wire
